// ===== src/sdt_pkg.sv =====
// Shared types and constants of the squared distance transform block.
package sdt_pkg;

    localparam int DIST_W = 30;
    localparam int CFG_W  = 9;

    localparam logic [DIST_W-1:0] NO_OBSTACLE_DIST = 30'd1000000000;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] MAP_SIZE_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] cell_index;
        logic        blocked;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0] sq_dist;
        logic              no_obstacle;
        logic              read_valid;
    } t_out;

    typedef struct packed {
        logic host_wr;
        logic host_rd;
        logic cap;
        logic run_start;
        logic line_init;
        logic ld_rd;
        logic ld_wr;
        logic bld_init;
        logic bq_rd;
        logic bk_rd;
        logic b_calc;
        logic b_mul;
        logic b_pop;
        logic b_push;
        logic s_init;
        logic s_rdb;
        logic s_chk;
        logic s_adv;
        logic s_rdv;
        logic s_out;
        logic next_line;
        logic next_pass;
    } t_dp_cmd;

    typedef struct packed {
        logic q_last;
        logic n_one;
        logic line_last;
        logic pass_row;
        logic k_lt_top;
        logic pop_ok;
        logic adv_ok;
    } t_dp_stat;

endpackage

// ===== src/sdt_dp.sv =====
// Datapath of the distance transform: map memories, envelope store and arithmetic.
module sdt_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [sdt_pkg::CFG_W-1:0] i_cfg_data,
    input  sdt_pkg::t_in              i_in,
    input  sdt_pkg::t_dp_cmd          i_cmd,
    output sdt_pkg::t_dp_stat         o_stat,
    output sdt_pkg::t_out             o_out
);

    localparam int LINE_CAP = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int LW       = $clog2(LINE_CAP);
    localparam int NW       = LW + 1;
    localparam int CELL_CAP = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = $clog2(CELL_CAP);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int EWW      = (WW > sdt_pkg::CFG_W) ? WW : sdt_pkg::CFG_W;
    localparam int EHW      = (HW > sdt_pkg::CFG_W) ? HW : sdt_pkg::CFG_W;
    localparam int CW       = WW + HW;
    localparam int CMPW     = (CW > 16) ? CW : 16;
    localparam int SW       = 2 * LW;
    localparam int FQW      = ((sdt_pkg::DIST_W > SW) ? sdt_pkg::DIST_W : SW) + 1;
    localparam int NUMW     = FQW + 1;
    localparam int DENW     = LW + 1;
    localparam int PW       = NUMW + DENW + 1;

    logic [sdt_pkg::CFG_W-1:0] r_map_width, r_map_height;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] cells;
    logic          in_range;
    logic [AW-1:0] host_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= sdt_pkg::MAP_SIZE_RESET;
            r_map_height <= sdt_pkg::MAP_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdt_pkg::CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                sdt_pkg::CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A size of zero acts as one; an oversize value saturates.
    always_comb begin
        if (r_map_width == '0) begin
            w_eff = WW'(1);
        end else if (EWW'(r_map_width) > EWW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_map_width);
        end
        if (r_map_height == '0) begin
            h_eff = HW'(1);
        end else if (EHW'(r_map_height) > EHW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_map_height);
        end
    end

    assign cells     = CW'(w_eff) * CW'(h_eff);
    assign in_range  = CMPW'(i_in.cell_index) < CMPW'(cells);
    assign host_addr = AW'(i_in.cell_index);

    // Counters of the run.
    logic          r_pass;
    logic [LW-1:0] r_q, r_k, r_top, r_line;
    logic [AW-1:0] r_addr, r_base;
    logic [NW-1:0] n_len_m1, lines_m1;
    logic [AW-1:0] stride, bstep;

    assign n_len_m1 = (r_pass ? NW'(w_eff) : NW'(h_eff)) - NW'(1);
    assign lines_m1 = (r_pass ? NW'(h_eff) : NW'(w_eff)) - NW'(1);
    assign stride   = r_pass ? AW'(1) : AW'(w_eff);
    assign bstep    = r_pass ? AW'(w_eff) : AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= 1'b0;
            r_q    <= '0;
            r_k    <= '0;
            r_top  <= '0;
            r_line <= '0;
            r_addr <= '0;
            r_base <= '0;
        end else begin
            if (i_cmd.run_start) begin
                r_pass <= 1'b0;
                r_line <= '0;
                r_base <= '0;
            end
            if (i_cmd.next_pass) begin
                r_pass <= 1'b1;
                r_line <= '0;
                r_base <= '0;
            end
            if (i_cmd.next_line) begin
                r_line <= r_line + LW'(1);
                r_base <= r_base + bstep;
            end
            if (i_cmd.line_init || i_cmd.s_init) begin
                r_q    <= '0;
                r_addr <= r_base;
            end
            if (i_cmd.s_init) begin
                r_k <= '0;
            end
            if (i_cmd.ld_wr || i_cmd.s_out) begin
                r_q    <= r_q + LW'(1);
                r_addr <= r_addr + stride;
            end
            if (i_cmd.bld_init) begin
                r_q   <= LW'(1);
                r_k   <= '0;
                r_top <= '0;
            end
            if (i_cmd.b_pop) begin
                r_k <= r_k - LW'(1);
            end
            if (i_cmd.b_push) begin
                r_k   <= r_k + LW'(1);
                r_top <= r_k + LW'(1);
                r_q   <= r_q + LW'(1);
            end
            if (i_cmd.s_adv) begin
                r_k <= r_k + LW'(1);
            end
        end
    end

    // Memories.
    logic                      mem_obs  [CELL_CAP];
    logic [sdt_pkg::DIST_W-1:0] mem_dist [CELL_CAP];
    logic [sdt_pkg::DIST_W-1:0] mem_lb   [LINE_CAP];
    logic [LW-1:0]             env_pos  [LINE_CAP];
    logic [sdt_pkg::DIST_W-1:0] env_f    [LINE_CAP];
    logic signed [NUMW-1:0]    env_bn   [LINE_CAP];
    logic [DENW-1:0]           env_bd   [LINE_CAP];

    logic                       r_obs_q;
    logic [sdt_pkg::DIST_W-1:0] r_dist_q, r_lb_q;
    logic [LW-1:0]              r_pos_q;
    logic [sdt_pkg::DIST_W-1:0] r_f_q;
    logic signed [NUMW-1:0]     r_bn_q;
    logic [DENW-1:0]            r_bd_q;

    logic [sdt_pkg::DIST_W-1:0] ld_val;
    logic                       dist_re;
    logic [AW-1:0]              dist_raddr;
    logic                       env_we, env_re;
    logic [LW-1:0]              env_waddr, env_raddr;
    logic [LW-1:0]              env_wpos;
    logic [sdt_pkg::DIST_W-1:0] env_wf;
    logic signed [NUMW-1:0]     env_wbn;
    logic [DENW-1:0]            env_wbd;
    logic [sdt_pkg::DIST_W-1:0] res;

    logic signed [NUMW-1:0] r_num;
    logic [DENW-1:0]        r_den;
    logic [FQW-1:0]         r_fq;
    logic signed [PW-1:0]   r_p1, r_p2;
    logic [SW-1:0]          qsq, vsq, dsq;
    logic [FQW-1:0]         fv_full;
    logic [LW-1:0]          dq;

    assign ld_val = r_pass ? r_dist_q : (r_obs_q ? '0 : sdt_pkg::NO_OBSTACLE_DIST);

    assign dist_re    = i_cmd.host_rd || i_cmd.ld_rd;
    assign dist_raddr = i_cmd.host_rd ? host_addr : r_addr;

    assign env_we    = (i_cmd.ld_wr && (r_q == '0)) || i_cmd.b_push;
    assign env_waddr = i_cmd.b_push ? (r_k + LW'(1)) : '0;
    assign env_wpos  = i_cmd.b_push ? r_q : '0;
    assign env_wf    = i_cmd.b_push ? r_lb_q : ld_val;
    assign env_wbn   = i_cmd.b_push ? r_num : '0;
    assign env_wbd   = i_cmd.b_push ? r_den : '0;
    assign env_re    = i_cmd.bk_rd || i_cmd.s_rdb || i_cmd.s_rdv;
    assign env_raddr = (i_cmd.s_rdb && o_stat.k_lt_top) ? (r_k + LW'(1)) : r_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.host_wr && in_range) begin
            mem_obs[host_addr] <= i_in.blocked;
        end
        if (i_cmd.ld_rd) begin
            r_obs_q <= mem_obs[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.s_out) begin
            mem_dist[r_addr] <= res;
        end
        if (dist_re) begin
            r_dist_q <= mem_dist[dist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr) begin
            mem_lb[r_q] <= ld_val;
        end
        if (i_cmd.bq_rd) begin
            r_lb_q <= mem_lb[r_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (env_we) begin
            env_pos[env_waddr] <= env_wpos;
            env_f[env_waddr]   <= env_wf;
            env_bn[env_waddr]  <= env_wbn;
            env_bd[env_waddr]  <= env_wbd;
        end
        if (env_re) begin
            r_pos_q <= env_pos[env_raddr];
            r_f_q   <= env_f[env_raddr];
            r_bn_q  <= env_bn[env_raddr];
            r_bd_q  <= env_bd[env_raddr];
        end
    end

    // Parabola arithmetic.
    assign qsq     = SW'(r_q) * SW'(r_q);
    assign vsq     = SW'(r_pos_q) * SW'(r_pos_q);
    assign fv_full = FQW'(r_f_q) + FQW'(vsq);
    assign dq      = (r_q >= r_pos_q) ? (r_q - r_pos_q) : (r_pos_q - r_q);
    assign dsq     = SW'(dq) * SW'(dq);
    assign res     = sdt_pkg::DIST_W'(FQW'(r_f_q) + FQW'(dsq));

    always_ff @(posedge i_clk) begin
        if (i_cmd.bk_rd) begin
            r_fq <= FQW'(r_lb_q) + FQW'(qsq);
        end
        if (i_cmd.b_calc) begin
            r_num <= $signed({1'b0, r_fq}) - $signed({1'b0, fv_full});
            r_den <= {r_q - r_pos_q, 1'b0};
        end
        if (i_cmd.b_mul) begin
            r_p1 <= PW'(r_num) * PW'($signed({1'b0, r_bd_q}));
            r_p2 <= PW'(r_bn_q) * PW'($signed({1'b0, r_den}));
        end
        if (i_cmd.s_chk) begin
            r_p1 <= PW'(r_bn_q);
            r_p2 <= PW'($signed({1'b0, r_q})) * PW'($signed({1'b0, r_bd_q}));
        end
    end

    assign o_stat.q_last    = {1'b0, r_q} == n_len_m1;
    assign o_stat.n_one     = n_len_m1 == '0;
    assign o_stat.line_last = {1'b0, r_line} == lines_m1;
    assign o_stat.pass_row  = r_pass;
    assign o_stat.k_lt_top  = r_k < r_top;
    assign o_stat.pop_ok    = (r_k != '0) && (r_p1 <= r_p2);
    assign o_stat.adv_ok    = r_p1 < r_p2;

    // Result fields of the item at the output register.
    logic r_out_rd, r_out_in;
    logic hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_out_rd <= i_cmd.host_rd;
            r_out_in <= in_range;
        end
    end

    assign hit               = r_out_rd && r_out_in;
    assign o_out.sq_dist     = hit ? r_dist_q : '0;
    assign o_out.no_obstacle = hit && (r_dist_q == sdt_pkg::NO_OBSTACLE_DIST);
    assign o_out.read_valid  = r_out_rd;

endmodule

// ===== src/sdt_ctrl.sv =====
// Controller state machine of the distance transform: handshakes and run sequencing.
module sdt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd_code,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sdt_pkg::t_dp_stat i_stat,
    output sdt_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [17:0] {
        ST_IDLE       = 18'h00001,
        ST_LINE_START = 18'h00002,
        ST_LD_RD      = 18'h00004,
        ST_LD_WR      = 18'h00008,
        ST_B_INIT     = 18'h00010,
        ST_B_RDQ      = 18'h00020,
        ST_B_RDK      = 18'h00040,
        ST_B_CALC     = 18'h00080,
        ST_B_MUL      = 18'h00100,
        ST_B_CMP      = 18'h00200,
        ST_S_INIT     = 18'h00400,
        ST_S_RDB      = 18'h00800,
        ST_S_CHK      = 18'h01000,
        ST_S_CMP      = 18'h02000,
        ST_S_RDV      = 18'h04000,
        ST_S_OUT      = 18'h08000,
        ST_LINE_END   = 18'h10000,
        ST_DONE       = 18'h20000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.cap       = accept;
                o_cmd.host_wr   = accept && (i_cmd_code == sdt_pkg::CMD_WRITE);
                o_cmd.host_rd   = accept && (i_cmd_code == sdt_pkg::CMD_READ);
                o_cmd.run_start = accept && (i_cmd_code == sdt_pkg::CMD_RUN);
                if (o_cmd.run_start) n_state = ST_LINE_START;
            end
            ST_LINE_START: begin
                o_cmd.line_init = 1'b1;
                n_state = ST_LD_RD;
            end
            ST_LD_RD: begin
                o_cmd.ld_rd = 1'b1;
                n_state = ST_LD_WR;
            end
            ST_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                n_state = i_stat.q_last ? ST_B_INIT : ST_LD_RD;
            end
            ST_B_INIT: begin
                o_cmd.bld_init = 1'b1;
                n_state = i_stat.n_one ? ST_S_INIT : ST_B_RDQ;
            end
            ST_B_RDQ: begin
                o_cmd.bq_rd = 1'b1;
                n_state = ST_B_RDK;
            end
            ST_B_RDK: begin
                o_cmd.bk_rd = 1'b1;
                n_state = ST_B_CALC;
            end
            ST_B_CALC: begin
                o_cmd.b_calc = 1'b1;
                n_state = ST_B_MUL;
            end
            ST_B_MUL: begin
                o_cmd.b_mul = 1'b1;
                n_state = ST_B_CMP;
            end
            ST_B_CMP: begin
                if (i_stat.pop_ok) begin
                    o_cmd.b_pop = 1'b1;
                    n_state = ST_B_RDK;
                end else begin
                    o_cmd.b_push = 1'b1;
                    n_state = i_stat.q_last ? ST_S_INIT : ST_B_RDQ;
                end
            end
            ST_S_INIT: begin
                o_cmd.s_init = 1'b1;
                n_state = ST_S_RDB;
            end
            ST_S_RDB: begin
                o_cmd.s_rdb = 1'b1;
                n_state = i_stat.k_lt_top ? ST_S_CHK : ST_S_OUT;
            end
            ST_S_CHK: begin
                o_cmd.s_chk = 1'b1;
                n_state = ST_S_CMP;
            end
            ST_S_CMP: begin
                if (i_stat.adv_ok) begin
                    o_cmd.s_adv = 1'b1;
                    n_state = ST_S_RDB;
                end else begin
                    n_state = ST_S_RDV;
                end
            end
            ST_S_RDV: begin
                o_cmd.s_rdv = 1'b1;
                n_state = ST_S_OUT;
            end
            ST_S_OUT: begin
                o_cmd.s_out = 1'b1;
                n_state = i_stat.q_last ? ST_LINE_END : ST_S_RDB;
            end
            ST_LINE_END: begin
                if (!i_stat.line_last) begin
                    o_cmd.next_line = 1'b1;
                    n_state = ST_LINE_START;
                end else if (!i_stat.pass_row) begin
                    o_cmd.next_pass = 1'b1;
                    n_state = ST_LINE_START;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (accept && (i_cmd_code != sdt_pkg::CMD_RUN)) n_out_valid = 1'b1;
        if (r_state == ST_DONE) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("controller state is not one-hot");
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd_code == sdt_pkg::CMD_RUN)) |=> (r_state == ST_LINE_START))
        else $error("accepted run did not start a line");
    a_busy_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_out_valid)
        else $error("result pending while a run is in progress");
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("run finished without a result");
`endif

endmodule

// ===== src/squared_distance_transform_top.sv =====
// Top level of the squared Euclidean distance transform block.
// Write and read items transfer at one per cycle while the output is not held back; a result is
// offered in the cycle after its item. A run item walks every column, then every row.
// Its result is offered when the run finishes; no item is taken meanwhile.
// Reset is synchronous, active low; map contents are undefined until written.
module squared_distance_transform_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [sdt_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  sdt_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output sdt_pkg::t_out             o_out
);

    // The controller owns both handshakes and sequences a run; the datapath holds the
    // obstacle map, the distance store, the line buffer and the envelope of parabolas.
    sdt_pkg::t_dp_cmd  dp_cmd;
    sdt_pkg::t_dp_stat dp_stat;

    sdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd_code  (i_in.cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Each transfer into the block is decoded by the controller; the datapath captures the
    // result fields in the same cycle so the output holds steady until its transfer.
    sdt_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out      (o_out)
    );

endmodule
